// ===== design/online_budgeted_bid_allocator_macros.svh =====
// Assertion macros for the bid allocator.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef ONLINE_BUDGETED_BID_ALLOCATOR_MACROS_SVH
`define ONLINE_BUDGETED_BID_ALLOCATOR_MACROS_SVH

// Condition holds at every edge out of reset.
`define BBA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bba_pkg.sv =====
// Shared types, widths and helpers for the bid allocator.
// No dependencies; every other file but the assertion macros header imports it.
package bba_pkg;

  localparam int ADV_W   = 5;
  localparam int LIM_W   = 24;
  localparam int PRICE_W = 16;
  localparam int BID_W   = 16;
  localparam int EFF_W   = 32;
  localparam int SUM_W   = 40;

  localparam logic [PRICE_W:0] ONE_FRAC = 17'h10000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BID  = 1'b1
  } op_t;

  // Store write port: loads write all three fields, commits skip the price.
  typedef struct packed {
    logic               en;
    logic               wr_price;
    logic [ADV_W-1:0]   addr;
    logic [LIM_W-1:0]   limit;
    logic [PRICE_W-1:0] price;
    logic [SUM_W-1:0]   revenue;
  } st_wr_t;

  typedef struct packed {
    logic [LIM_W-1:0]   limit;
    logic [PRICE_W-1:0] price;
    logic [SUM_W-1:0]   revenue;
  } st_rd_t;

  // Winner handed from the selection stage to the commit stage.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [ADV_W-1:0]   index;
    logic [EFF_W-1:0]   eff;
    logic [BID_W-1:0]   bid;
  } cmt_req_t;

  typedef struct packed {
    logic s1_last;
    logic s2_last;
    logic best_found;
  } sel_stat_t;

  typedef struct packed {
    logic s3_busy;
    logic s4_busy;
  } cmt_stat_t;

  function automatic logic [SUM_W-1:0] sat_add40(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ===== design/bba_if.sv =====
// Valid/ready channel interfaces for the bid allocator input and result.
// Depends on bba_pkg for field widths.
interface bba_in_if;
  import bba_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [ADV_W-1:0]   advertiser;
  logic [LIM_W-1:0]   budget;
  logic [PRICE_W-1:0] price;
  logic [BID_W-1:0]   bid;
  logic               last_bid;

  modport source (output valid, operation, advertiser, budget, price, bid, last_bid,
                  input ready);
  modport sink (input valid, operation, advertiser, budget, price, bid, last_bid,
                output ready);
endinterface

interface bba_out_if;
  import bba_pkg::*;
  logic               valid;
  logic               ready;
  logic               matched;
  logic [ADV_W-1:0]   winner;
  logic [EFF_W-1:0]   winning_effective_bid;
  logic [BID_W-1:0]   charged;
  logic [BID_W-1:0]   overflow;
  logic [LIM_W-1:0]   remaining_limit;
  logic [SUM_W-1:0]   winner_revenue;
  logic [SUM_W-1:0]   total_charged;
  logic [SUM_W-1:0]   total_overflow;
  logic [SUM_W-1:0]   total_bids;

  modport source (output valid, matched, winner, winning_effective_bid, charged, overflow,
                  remaining_limit, winner_revenue, total_charged, total_overflow,
                  total_bids,
                  input ready);
  modport sink (input valid, matched, winner, winning_effective_bid, charged, overflow,
                remaining_limit, winner_revenue, total_charged, total_overflow,
                total_bids,
                output ready);
endinterface

// ===== design/bba_store.sv =====
// Advertiser state memories: limit, price and revenue, one read and one write port.
// Read data is registered. Depends on bba_pkg.
module bba_store #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  bba_pkg::st_wr_t wr,
  input  logic [bba_pkg::ADV_W-1:0] rd_addr,
  output bba_pkg::st_rd_t rd
);
  import bba_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LIM_W-1:0]   limit_mem   [DEPTH];
  logic [PRICE_W-1:0] price_mem   [DEPTH];
  logic [SUM_W-1:0]   revenue_mem [DEPTH];

  logic [LIM_W-1:0]   limit_r;
  logic [PRICE_W-1:0] price_r;
  logic [SUM_W-1:0]   revenue_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      limit_mem[wr.addr[AW-1:0]]   <= wr.limit;
      revenue_mem[wr.addr[AW-1:0]] <= wr.revenue;
      if (wr.wr_price) begin
        price_mem[wr.addr[AW-1:0]] <= wr.price;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r   <= limit_mem[rd_addr[AW-1:0]];
    price_r   <= price_mem[rd_addr[AW-1:0]];
    revenue_r <= revenue_mem[rd_addr[AW-1:0]];
  end

  assign rd = '{limit: limit_r, price: price_r, revenue: revenue_r};

endmodule

// ===== design/bba_select.sv =====
// Bid selection: effective-bid multiply, then compare against the running best.
// Hands the winner to the commit stage on the final bid. Depends on bba_pkg.
module bba_select (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        bid_fire,
  input  logic [bba_pkg::ADV_W-1:0]   adv,
  input  logic [bba_pkg::BID_W-1:0]   bid,
  input  logic                        last_bid,
  input  logic                        in_range,
  input  bba_pkg::st_rd_t             rd,
  output bba_pkg::cmt_req_t           cmt_req,
  output bba_pkg::sel_stat_t          stat
);
  import bba_pkg::*;

  // S1: bid waits for its store read
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_last_r;
  logic               s1_range_r;
  logic [ADV_W-1:0]   s1_adv_r;
  logic [BID_W-1:0]   s1_bid_r;

  // S2: product registered, compare against best
  logic               s2_valid_r, s2_valid_nxt;
  logic               s2_last_r;
  logic               s2_compete_r;
  logic [ADV_W-1:0]   s2_adv_r;
  logic [BID_W-1:0]   s2_bid_r;
  logic [EFF_W-1:0]   s2_eff_r;

  logic               best_found_r, best_found_nxt;
  logic [ADV_W-1:0]   best_index_r, best_index_nxt;
  logic [EFF_W-1:0]   best_eff_r, best_eff_nxt;
  logic [BID_W-1:0]   best_bid_r, best_bid_nxt;

  logic [EFF_W:0]     prod;
  logic               compete;
  logic               take;
  logic               commit;
  logic               upd_found;
  logic [ADV_W-1:0]   upd_index;
  logic [EFF_W-1:0]   upd_eff;
  logic [BID_W-1:0]   upd_bid;

  assign s1_valid_nxt = bid_fire;
  assign s2_valid_nxt = s1_valid_r;

  always_comb begin
    prod    = (EFF_W+1)'(s1_bid_r) * ((EFF_W+1)'(ONE_FRAC) - (EFF_W+1)'(rd.price));
    compete = s1_range_r && (rd.limit != '0);
  end

  always_comb begin
    take      = s2_valid_r && s2_compete_r && (!best_found_r || (best_eff_r < s2_eff_r));
    upd_found = take ? 1'b1     : best_found_r;
    upd_index = take ? s2_adv_r : best_index_r;
    upd_eff   = take ? s2_eff_r : best_eff_r;
    upd_bid   = take ? s2_bid_r : best_bid_r;
    commit    = s2_valid_r && s2_last_r;
    // drop the best at the end of each query
    best_found_nxt = commit ? 1'b0 : upd_found;
    best_index_nxt = commit ? '0   : upd_index;
    best_eff_nxt   = commit ? '0   : upd_eff;
    best_bid_nxt   = commit ? '0   : upd_bid;
  end

  assign cmt_req = '{valid: commit, found: upd_found, index: upd_index,
                     eff: upd_eff, bid: upd_bid};
  assign stat = '{s1_last: s1_valid_r && s1_last_r, s2_last: commit,
                  best_found: best_found_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      best_found_r <= 1'b0;
      best_index_r <= '0;
      best_eff_r   <= '0;
      best_bid_r   <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      best_found_r <= best_found_nxt;
      best_index_r <= best_index_nxt;
      best_eff_r   <= best_eff_nxt;
      best_bid_r   <= best_bid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r    <= last_bid;
    s1_range_r   <= in_range;
    s1_adv_r     <= adv;
    s1_bid_r     <= bid;
    s2_last_r    <= s1_last_r;
    s2_compete_r <= compete;
    s2_adv_r     <= s1_adv_r;
    s2_bid_r     <= s1_bid_r;
    s2_eff_r     <= prod[EFF_W-1:0];
  end

endmodule

// ===== design/bba_commit.sv =====
// Commit: charge the winner, update its limit and revenue, fold the totals,
// and hold the result in the output register. Depends on bba_pkg, bba_out_if.
module bba_commit (
  input  logic               clk,
  input  logic               rst_n,
  input  bba_pkg::cmt_req_t  cmt_req,
  input  bba_pkg::st_rd_t    rd,
  output bba_pkg::st_wr_t    wr,
  output bba_pkg::cmt_stat_t stat,
  bba_out_if.source          out_chan
);
  import bba_pkg::*;

  logic               s3_valid_r, s3_valid_nxt;
  cmt_req_t           s3_req_r;

  logic               s4_valid_r, s4_valid_nxt;
  logic               s4_found_r;
  logic [ADV_W-1:0]   s4_index_r;
  logic [EFF_W-1:0]   s4_eff_r;
  logic [BID_W-1:0]   s4_bid_r;
  logic [BID_W-1:0]   s4_chg_r;
  logic [BID_W-1:0]   s4_ovf_r;
  logic [LIM_W-1:0]   s4_lim_r;
  logic [2*BID_W-1:0] s4_gain_r;
  logic [SUM_W-1:0]   s4_rev_r;

  logic [SUM_W-1:0]   sum_chg_r, sum_chg_nxt;
  logic [SUM_W-1:0]   sum_ovf_r, sum_ovf_nxt;
  logic [SUM_W-1:0]   sum_bid_r, sum_bid_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               matched_r;
  logic [ADV_W-1:0]   winner_r;
  logic [EFF_W-1:0]   eff_r;
  logic [BID_W-1:0]   chg_r;
  logic [BID_W-1:0]   ovf_r;
  logic [LIM_W-1:0]   lim_r;
  logic [SUM_W-1:0]   rev_r;

  logic [LIM_W-1:0]   bid_ext;
  logic [BID_W-1:0]   chg;
  logic [BID_W-1:0]   ovf;
  logic [LIM_W-1:0]   new_lim;
  logic [2*BID_W-1:0] gain;
  logic [SUM_W-1:0]   new_rev;
  logic               done;

  // S3: winner's state is on the read port this cycle
  always_comb begin
    bid_ext = LIM_W'(s3_req_r.bid);
    if (rd.limit < bid_ext) begin
      chg = rd.limit[BID_W-1:0];
      ovf = s3_req_r.bid - rd.limit[BID_W-1:0];
    end else begin
      chg = s3_req_r.bid;
      ovf = '0;
    end
    new_lim = rd.limit - LIM_W'(chg);
    gain    = (2*BID_W)'(s3_req_r.bid) * (2*BID_W)'(rd.price);
  end

  // S4: saturating accumulates, retire into the output register
  always_comb begin
    done        = s4_valid_r && (!out_valid_r || out_chan.ready);
    new_rev     = sat_add40(s4_rev_r, SUM_W'(s4_gain_r));
    sum_chg_nxt = sum_chg_r;
    sum_ovf_nxt = sum_ovf_r;
    sum_bid_nxt = sum_bid_r;
    if (done && s4_found_r) begin
      sum_chg_nxt = sat_add40(sum_chg_r, SUM_W'(s4_chg_r));
      sum_ovf_nxt = sat_add40(sum_ovf_r, SUM_W'(s4_ovf_r));
      sum_bid_nxt = sat_add40(sum_bid_r, SUM_W'(s4_bid_r));
    end
  end

  assign s3_valid_nxt  = cmt_req.valid;
  assign s4_valid_nxt  = s3_valid_r || (s4_valid_r && !done);
  assign out_valid_nxt = done || (out_valid_r && !out_chan.ready);

  assign wr = '{en: done && s4_found_r, wr_price: 1'b0, addr: s4_index_r,
                limit: s4_lim_r, price: '0, revenue: new_rev};
  assign stat = '{s3_busy: s3_valid_r, s4_busy: s4_valid_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_chg_r   <= '0;
      sum_ovf_r   <= '0;
      sum_bid_r   <= '0;
    end else begin
      s3_valid_r  <= s3_valid_nxt;
      s4_valid_r  <= s4_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sum_chg_r   <= sum_chg_nxt;
      sum_ovf_r   <= sum_ovf_nxt;
      sum_bid_r   <= sum_bid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmt_req.valid) begin
      s3_req_r <= cmt_req;
    end
    if (s3_valid_r) begin
      s4_found_r <= s3_req_r.found;
      s4_index_r <= s3_req_r.index;
      s4_eff_r   <= s3_req_r.eff;
      s4_bid_r   <= s3_req_r.bid;
      s4_chg_r   <= chg;
      s4_ovf_r   <= ovf;
      s4_lim_r   <= new_lim;
      s4_gain_r  <= gain;
      s4_rev_r   <= rd.revenue;
    end
    if (done) begin
      matched_r <= s4_found_r;
      winner_r  <= s4_found_r ? s4_index_r : '0;
      eff_r     <= s4_found_r ? s4_eff_r   : '0;
      chg_r     <= s4_found_r ? s4_chg_r   : '0;
      ovf_r     <= s4_found_r ? s4_ovf_r   : '0;
      lim_r     <= s4_found_r ? s4_lim_r   : '0;
      rev_r     <= s4_found_r ? new_rev    : '0;
    end
  end

  assign out_chan.valid                 = out_valid_r;
  assign out_chan.matched               = matched_r;
  assign out_chan.winner                = winner_r;
  assign out_chan.winning_effective_bid = eff_r;
  assign out_chan.charged               = chg_r;
  assign out_chan.overflow              = ovf_r;
  assign out_chan.remaining_limit       = lim_r;
  assign out_chan.winner_revenue        = rev_r;
  assign out_chan.total_charged         = sum_chg_r;
  assign out_chan.total_overflow        = sum_ovf_r;
  assign out_chan.total_bids            = sum_bid_r;

endmodule

// ===== design/online_budgeted_bid_allocator.sv =====
// Online budgeted bid allocator. Loads and non-final bids are taken one per
// cycle while no query is in commit. A final bid closes the query: the
// winner's limit, price and revenue are read back from the state memories,
// and its limit and revenue written after the charge; the next item is taken
// once the result enters the output register, which waits while it is full.
// Loads for advertisers at or above MAX_ADVERTISERS are ignored and bids for
// them never win; reading an advertiser never loaded gives undefined results.
// Depends on bba_pkg, bba_if, bba_store, bba_select, bba_commit.
`include "online_budgeted_bid_allocator_macros.svh"

module online_budgeted_bid_allocator #(
  parameter int MAX_ADVERTISERS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bba_in_if.sink     in_chan,
  bba_out_if.source  out_chan
);
  import bba_pkg::*;

  localparam int DEPTH = (MAX_ADVERTISERS < 2**ADV_W) ? MAX_ADVERTISERS : 2**ADV_W;

  logic       in_fire;
  logic       adv_in_range;
  logic       bid_fire;
  st_wr_t     ld_wr;
  st_wr_t     cmt_wr;
  st_wr_t     wr;
  st_rd_t     rd;
  logic [ADV_W-1:0] rd_addr;
  cmt_req_t   cmt_req;
  sel_stat_t  sel_stat;
  cmt_stat_t  cmt_stat;

  // hold input while a query is being committed
  assign in_chan.ready = !sel_stat.s1_last && !sel_stat.s2_last &&
                         !cmt_stat.s3_busy && !cmt_stat.s4_busy;
  assign in_fire      = in_chan.valid && in_chan.ready;
  assign adv_in_range = (32'(in_chan.advertiser) < 32'(MAX_ADVERTISERS));
  assign bid_fire     = in_fire && (in_chan.operation == OP_BID);

  assign ld_wr = '{en: in_fire && (in_chan.operation == OP_LOAD) && adv_in_range,
                   wr_price: 1'b1, addr: in_chan.advertiser, limit: in_chan.budget,
                   price: in_chan.price, revenue: '0};
  assign wr      = cmt_wr.en ? cmt_wr : ld_wr;
  assign rd_addr = cmt_req.valid ? cmt_req.index : in_chan.advertiser;

  bba_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  bba_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .bid_fire (bid_fire),
    .adv      (in_chan.advertiser),
    .bid      (in_chan.bid),
    .last_bid (in_chan.last_bid),
    .in_range (adv_in_range),
    .rd       (rd),
    .cmt_req  (cmt_req),
    .stat     (sel_stat)
  );

  bba_commit u_commit (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmt_req  (cmt_req),
    .rd       (rd),
    .wr       (cmt_wr),
    .stat     (cmt_stat),
    .out_chan (out_chan)
  );

  `BBA_ASSERT_ALWAYS(a_one_commit, $onehot0({sel_stat.s1_last, sel_stat.s2_last, cmt_stat.s3_busy, cmt_stat.s4_busy}), "more than one query commit in flight")
  `BBA_ASSERT_NEXT(a_best_cleared, cmt_req.valid, !sel_stat.best_found, "best bid not cleared after query close")
  `BBA_ASSERT_ALWAYS(a_unmatched_zero, !(out_chan.valid && !out_chan.matched) || (out_chan.winner == '0 && out_chan.charged == '0 && out_chan.winner_revenue == '0), "unmatched result carries winner data")

endmodule
